// ===== rtl/onewire_rom_search_engine_top_defines.svh =====
// Assertion macros shared by the Search ROM engine RTL.
// No dependencies; taken in by `include where checks are written.
`ifndef ONEWIRE_ROM_SEARCH_ENGINE_TOP_DEFINES_SVH
`define ONEWIRE_ROM_SEARCH_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ORS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ors: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ORS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ors: next-cycle check failed");

`endif

// ===== rtl/ors_pkg.sv =====
// Types and constants for the 1-Wire Search ROM engine.
// No dependencies; imported by every module of the block.
package ors_pkg;

    localparam int ROM_W      = 64;
    localparam int POS_W      = 7;
    localparam int IDX_W      = 6;
    localparam int QUEUE_DEPTH = 4;   // power of two, pointers wrap naturally
    localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);

    // Item class decided at the front
    typedef enum logic [1:0] {
        OP_START     = 2'd0,   // load deviation, restart the walk
        OP_PAIR_ONES = 2'd1,   // both slots read one: nobody answered
        OP_DIRECT    = 2'd2,   // exactly one slot set: bit is forced
        OP_BRANCH    = 2'd3    // both slots zero: devices disagree
    } ors_op_t;

    typedef struct packed {
        ors_op_t          op;
        logic [POS_W-1:0] last_deviation;
        logic             true_bit;
    } ors_entry_t;

    // Entry together with its valid flag, passed between the stages
    typedef struct packed {
        logic       valid;
        ors_entry_t entry;
    } ors_slot_t;

endpackage

// ===== rtl/ors_front.sv =====
// Front stage: registers incoming transfers and classifies each one.
// Depends on ors_pkg; feeds ors_queue.
module ors_front
    import ors_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_cmd,
    input  logic [POS_W-1:0] s_last_deviation,
    input  logic             s_true_bit,
    input  logic             s_complement_bit,
    output ors_slot_t        push,
    input  logic             queue_full
);

    logic       valid_reg, valid_next;
    ors_entry_t entry_reg, entry_class;
    logic       in_fire, drain;

    assign drain   = valid_reg && !queue_full;
    assign s_ready = !valid_reg || !queue_full;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        entry_class.last_deviation = s_last_deviation;
        entry_class.true_bit       = s_true_bit;
        if (!s_cmd) begin
            entry_class.op = OP_START;
        end else if (s_true_bit && s_complement_bit) begin
            entry_class.op = OP_PAIR_ONES;
        end else if (s_true_bit ^ s_complement_bit) begin
            entry_class.op = OP_DIRECT;
        end else begin
            entry_class.op = OP_BRANCH;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_fire) begin
            valid_next = 1'b1;
        end else if (drain) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            entry_reg <= entry_class;
        end
    end

    assign push.valid = drain;
    assign push.entry = entry_reg;

endmodule

// ===== rtl/ors_queue.sv =====
// Short FIFO between the front and back stages of the Search ROM engine.
// Depends on ors_pkg and the assertion macro header.
`include "onewire_rom_search_engine_top_defines.svh"
module ors_queue
    import ors_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  ors_slot_t push,
    output logic      full,
    output ors_slot_t head,
    input  logic      pop
);

    localparam logic [QUEUE_AW:0] DepthW = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    ors_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push, do_pop;

    assign full       = (count_reg == DepthW);
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid;
    assign do_pop     = pop;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

    `ORS_ASSERT_IMPL(a_no_push_full, aclk, aresetn, do_push, !full)
    `ORS_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, do_pop, head.valid)
    `ORS_ASSERT_NEXT(a_count_up, aclk, aresetn, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== rtl/ors_back.sv =====
// Back stage: runs the Search ROM bit walk and holds the result register.
// Depends on ors_pkg and the assertion macro header; fed by ors_queue.
`include "onewire_rom_search_engine_top_defines.svh"
module ors_back
    import ors_pkg::*;
#(
    parameter int ROM_BITS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ors_slot_t        head,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_write_bit,
    output logic [POS_W-1:0] m_bit_position,
    output logic             m_search_done,
    output logic             m_status,
    output logic [ROM_W-1:0] m_rom_code,
    output logic [POS_W-1:0] m_next_deviation
);

    localparam logic [POS_W-1:0] RomBitsW = POS_W'(ROM_BITS);

    // walk state
    logic [ROM_W-1:0] rom_pattern_reg, rom_pattern_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic [POS_W-1:0] prior_dev_reg, prior_dev_next;
    logic [POS_W-1:0] newest_dev_reg, newest_dev_next;
    logic             searching_reg, searching_next;

    // result register
    logic             m_valid_reg, m_valid_next;
    logic             res_wbit_next, res_done_next, res_status_next;
    logic [ROM_W-1:0] res_rom_next;
    logic [POS_W-1:0] res_dev_next;
    logic             m_write_bit_reg, m_search_done_reg, m_status_reg;
    logic [POS_W-1:0] m_bit_position_reg, m_next_deviation_reg;
    logic [ROM_W-1:0] m_rom_code_reg;

    logic             take, emit, last_bit;
    logic [IDX_W-1:0] idx;
    logic             cur_bit, new_bit, pos_eq, pos_gt, dev_hit;
    logic [POS_W-1:0] newest_after;

    assign take     = head.valid && (!m_valid_reg || m_ready);
    assign pop      = take;
    assign idx      = IDX_W'(position_reg - 1'b1);
    assign cur_bit  = rom_pattern_reg[idx];
    assign pos_eq   = (position_reg == prior_dev_reg);
    assign pos_gt   = (position_reg > prior_dev_reg);
    assign last_bit = (position_reg >= RomBitsW);

    always_comb begin
        if (head.entry.op == OP_DIRECT) begin
            new_bit = head.entry.true_bit;
        end else if (pos_eq) begin
            new_bit = 1'b1;
        end else if (pos_gt) begin
            new_bit = 1'b0;
        end else begin
            new_bit = cur_bit;
        end
        dev_hit      = (head.entry.op == OP_BRANCH) && (pos_gt || (!pos_eq && !cur_bit));
        newest_after = dev_hit ? position_reg : newest_dev_reg;
    end

    always_comb begin
        rom_pattern_next = rom_pattern_reg;
        position_next    = position_reg;
        prior_dev_next   = prior_dev_reg;
        newest_dev_next  = newest_dev_reg;
        searching_next   = searching_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        emit             = 1'b0;
        res_wbit_next    = 1'b0;
        res_done_next    = 1'b0;
        res_status_next  = 1'b0;
        res_rom_next     = rom_pattern_reg;
        res_dev_next     = '0;
        if (take) begin
            case (head.entry.op)
                OP_START: begin
                    prior_dev_next  = head.entry.last_deviation;
                    position_next   = POS_W'(1);
                    newest_dev_next = '0;
                    searching_next  = 1'b1;
                end
                OP_PAIR_ONES: begin
                    if (searching_reg) begin
                        emit            = 1'b1;
                        searching_next  = 1'b0;
                        res_done_next   = 1'b1;
                        res_status_next = 1'b1;
                    end
                end
                OP_DIRECT, OP_BRANCH: begin
                    if (searching_reg) begin
                        emit                  = 1'b1;
                        rom_pattern_next[idx] = new_bit;
                        newest_dev_next       = newest_after;
                        res_wbit_next         = new_bit;
                        res_done_next         = last_bit;
                        res_rom_next          = rom_pattern_next;
                        res_dev_next          = newest_after;
                        if (last_bit) begin
                            searching_next = 1'b0;
                        end else begin
                            position_next = position_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_pattern_reg <= '0;
            position_reg    <= POS_W'(1);
            prior_dev_reg   <= '0;
            newest_dev_reg  <= '0;
            searching_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            rom_pattern_reg <= rom_pattern_next;
            position_reg    <= position_next;
            prior_dev_reg   <= prior_dev_next;
            newest_dev_reg  <= newest_dev_next;
            searching_reg   <= searching_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_write_bit_reg      <= res_wbit_next;
            m_bit_position_reg   <= position_reg;
            m_search_done_reg    <= res_done_next;
            m_status_reg         <= res_status_next;
            m_rom_code_reg       <= res_rom_next;
            m_next_deviation_reg <= res_dev_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_write_bit      = m_write_bit_reg;
    assign m_bit_position   = m_bit_position_reg;
    assign m_search_done    = m_search_done_reg;
    assign m_status         = m_status_reg;
    assign m_rom_code       = m_rom_code_reg;
    assign m_next_deviation = m_next_deviation_reg;

    `ORS_ASSERT_IMPL(a_pos_range, aclk, aresetn, searching_reg, position_reg != '0 && position_reg <= RomBitsW)
    `ORS_ASSERT_IMPL(a_abort_fields, aclk, aresetn, m_valid_reg && m_status_reg, m_search_done_reg && !m_write_bit_reg && m_next_deviation_reg == '0)
    `ORS_ASSERT_NEXT(a_done_stops, aclk, aresetn, emit && res_done_next, !searching_reg && m_valid_reg)
    `ORS_ASSERT_IMPL(a_emit_needs_room, aclk, aresetn, emit, !m_valid_reg || m_ready)

endmodule

// ===== rtl/onewire_rom_search_engine_top.sv =====
// Search ROM engine: an input transfer passes front register, 4-entry queue and back
// result register in turn. Throughput one item per cycle unless m_ready stalls results.
// A result stalled at m_ is absorbed by the queue; s_ready drops once it is full and
// the front register is occupied. Reset (aresetn, synchronous, active low): walk idle,
// position 1, pattern and deviations cleared, queue and result register empty.
// Depends on ors_pkg, ors_front, ors_queue and ors_back.
module onewire_rom_search_engine_top
    import ors_pkg::*;
#(
    parameter int ROM_BITS = 64   // bits per ROM code, 8 to 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    // input channel: start command or one sampled bit pair
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_cmd,
    input  logic [POS_W-1:0] s_last_deviation,
    input  logic             s_true_bit,
    input  logic             s_complement_bit,
    // result channel: one transfer per resolved bit or abort while searching
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_write_bit,
    output logic [POS_W-1:0] m_bit_position,
    output logic             m_search_done,
    output logic             m_status,
    output logic [ROM_W-1:0] m_rom_code,
    output logic [POS_W-1:0] m_next_deviation
);

    // front -> queue -> back
    ors_slot_t push;
    ors_slot_t head;
    logic      queue_full;
    logic      pop;

    // Front: takes each transfer into a register and tags it as a start,
    // a forced bit, a branch point or an abort (both slots high).
    ors_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_last_deviation (s_last_deviation),
        .s_true_bit       (s_true_bit),
        .s_complement_bit (s_complement_bit),
        .push             (push),
        .queue_full       (queue_full)
    );

    // Queue decouples the front from result back-pressure.
    ors_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (queue_full),
        .head    (head),
        .pop     (pop)
    );

    // Back: owns the walk state. Bit items arriving while idle are dropped,
    // starts never produce a result.
    ors_back #(
        .ROM_BITS (ROM_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_write_bit      (m_write_bit),
        .m_bit_position   (m_bit_position),
        .m_search_done    (m_search_done),
        .m_status         (m_status),
        .m_rom_code       (m_rom_code),
        .m_next_deviation (m_next_deviation)
    );

endmodule
